/* hw/rtl/tpcq_pkg.sv */
package tpcq_pkg;

    // Depth of each command queue and the widths that follow from it.
    localparam int QUEUE_DEPTH = 128;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_ENQ_NORMAL = 2'd0,
        OP_ENQ_URGENT = 2'd1,
        OP_EXECUTE    = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    // Back end sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_back_state;

    // One input item as it arrives on the push side.
    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] motion;
        logic [7:0] speed;
        logic [7:0] duration;
    } t_in_item;

    // One stored command word.
    typedef struct packed {
        logic [2:0] motion;
        logic [7:0] speed;
        logic [7:0] duration;
    } t_cmd;

    // One result item as it leaves on the pop side.
    typedef struct packed {
        logic        command_valid;
        logic [2:0]  out_motion;
        logic [7:0]  out_speed;
        logic [7:0]  out_duration;
        logic        was_urgent;
        logic        queue_full;
        logic [31:0] elapsed_time;
        logic [31:0] weighted_speed_sum;
        logic [31:0] run_time_total;
        logic [15:0] normal_count;
        logic [7:0]  max_speed;
    } t_out_item;

endpackage

/* hw/rtl/two_level_priority_command_queue_core.sv */
// Path: an enqueue, a no-op or an execute on two empty queues passes the front slot
// and the result register; an execute that pops a command also passes the store read.
// Throughput: one enqueue per cycle unless full or an unpopped result holds the flow;
// an execute that pops holds the back end during the registered command store read.
// Reset (synchronous, active low) empties both queues and clears all totals;
// the command stores themselves are not cleared.
module two_level_priority_command_queue_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  tpcq_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output tpcq_pkg::t_out_item o_result
);
    import tpcq_pkg::*;

    t_in_item front_item;
    logic     link_avail;
    logic     link_take;

    // Front end: accepts items into a short queue.
    tpcq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .o_item  (front_item),
        .o_avail (link_avail),
        .i_take  (link_take)
    );

    // Back end: runs the command queues and the statistics.
    tpcq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (front_item),
        .i_avail  (link_avail),
        .o_take   (link_take),
        .o_result (o_result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

/* hw/rtl/tpcq_ram.sv */
module tpcq_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 19
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Single registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* hw/rtl/tpcq_front.sv */
module tpcq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  tpcq_pkg::t_in_item i_item,
    output tpcq_pkg::t_in_item o_item,
    output logic              o_avail,
    input  logic              i_take
);
    import tpcq_pkg::*;

    t_in_item   r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push_ok;
    logic       take_ok;

    assign full    = (r_count == 2'd2);
    assign o_avail = (r_count != 2'd0);
    assign o_item  = r_slot[r_rd_ptr];
    assign push_ok = push && !full;
    assign take_ok = i_take && o_avail;

    // Occupancy follows the transfers on both sides.
    always_comb begin
        n_count = r_count;
        if (push_ok && !take_ok) begin
            n_count = r_count + 2'd1;
        end else if (take_ok && !push_ok) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (take_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Item slots.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* hw/rtl/tpcq_back.sv */
module tpcq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tpcq_pkg::t_in_item  i_item,
    input  logic                i_avail,
    output logic                o_take,
    output tpcq_pkg::t_out_item o_result,
    output logic                empty,
    input  logic                pop
);
    import tpcq_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [PTR_W-1:0]  r_u_head, r_u_tail, r_n_head, r_n_tail;
    logic [PTR_W-1:0]  n_u_head, n_u_tail, n_n_head, n_n_tail;
    logic [FILL_W-1:0] r_u_fill, r_n_fill, n_u_fill, n_n_fill;
    logic              r_sel_urgent, n_sel_urgent;

    logic [31:0] r_time_total, r_speed_time, r_normal_time;
    logic [31:0] n_time_total, n_speed_time, n_normal_time;
    logic [15:0] r_normal_cnt, n_normal_cnt;
    logic [7:0]  r_peak, n_peak;

    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      out_load;
    logic      out_free;

    logic       u_we, n_we, u_re, n_re;
    t_cmd       wr_cmd;
    t_cmd       u_rdata, n_rdata, rd_cmd;
    logic [15:0] product;
    t_op        op;
    logic       u_has, n_has, u_isfull, n_isfull;

    // Saturating 32-bit add.
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Pointer step with wrap at the queue depth.
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign op        = t_op'(i_item.operation);
    assign u_has     = (r_u_fill != '0);
    assign n_has     = (r_n_fill != '0);
    assign u_isfull  = (r_u_fill == FILL_W'(QUEUE_DEPTH));
    assign n_isfull  = (r_n_fill == FILL_W'(QUEUE_DEPTH));
    assign out_free  = !r_out_valid || pop;
    assign wr_cmd    = '{motion: i_item.motion, speed: i_item.speed,
                         duration: i_item.duration};
    assign rd_cmd    = r_sel_urgent ? u_rdata : n_rdata;
    assign product   = 16'(rd_cmd.speed) * 16'(rd_cmd.duration);
    assign o_result  = r_out;
    assign empty     = !r_out_valid;

    // Command stores.
    tpcq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(t_cmd))) u_urgent_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (r_u_tail),
        .i_wdata (wr_cmd),
        .i_re    (u_re),
        .i_raddr (r_u_head),
        .o_rdata (u_rdata)
    );

    tpcq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(t_cmd))) u_normal_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_n_tail),
        .i_wdata (wr_cmd),
        .i_re    (n_re),
        .i_raddr (r_n_head),
        .o_rdata (n_rdata)
    );

    // Next state: an execute that finds a command moves to ST_EXEC for the store read.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_avail && out_free && (op == OP_EXECUTE) && (u_has || n_has)) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath control, queue bookkeeping and statistics.
    always_comb begin
        o_take        = 1'b0;
        u_we          = 1'b0;
        n_we          = 1'b0;
        u_re          = 1'b0;
        n_re          = 1'b0;
        n_u_head      = r_u_head;
        n_u_tail      = r_u_tail;
        n_u_fill      = r_u_fill;
        n_n_head      = r_n_head;
        n_n_tail      = r_n_tail;
        n_n_fill      = r_n_fill;
        n_sel_urgent  = r_sel_urgent;
        n_time_total  = r_time_total;
        n_speed_time  = r_speed_time;
        n_normal_time = r_normal_time;
        n_normal_cnt  = r_normal_cnt;
        n_peak        = r_peak;
        out_load      = 1'b0;
        n_out         = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_avail && out_free) begin
                    o_take = 1'b1;
                    unique case (op)
                        OP_ENQ_NORMAL: begin
                            out_load = 1'b1;
                            if (n_isfull) begin
                                n_out.queue_full = 1'b1;
                            end else begin
                                n_we     = 1'b1;
                                n_n_tail = ptr_next(r_n_tail);
                                n_n_fill = r_n_fill + FILL_W'(1);
                            end
                        end
                        OP_ENQ_URGENT: begin
                            out_load = 1'b1;
                            if (u_isfull) begin
                                n_out.queue_full = 1'b1;
                            end else begin
                                u_we     = 1'b1;
                                n_u_tail = ptr_next(r_u_tail);
                                n_u_fill = r_u_fill + FILL_W'(1);
                            end
                        end
                        OP_EXECUTE: begin
                            if (u_has) begin
                                u_re         = 1'b1;
                                n_u_head     = ptr_next(r_u_head);
                                n_u_fill     = r_u_fill - FILL_W'(1);
                                n_sel_urgent = 1'b1;
                            end else if (n_has) begin
                                n_re         = 1'b1;
                                n_n_head     = ptr_next(r_n_head);
                                n_n_fill     = r_n_fill - FILL_W'(1);
                                n_sel_urgent = 1'b0;
                            end else begin
                                out_load = 1'b1;
                            end
                        end
                        OP_NONE: begin
                            out_load = 1'b1;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_EXEC: begin
                out_load           = 1'b1;
                n_out.command_valid = 1'b1;
                n_out.out_motion   = rd_cmd.motion;
                n_out.out_speed    = rd_cmd.speed;
                n_out.out_duration = rd_cmd.duration;
                n_out.was_urgent   = r_sel_urgent;
                n_time_total       = sat_add32(r_time_total, 32'(rd_cmd.duration));
                if (!r_sel_urgent) begin
                    n_speed_time  = sat_add32(r_speed_time, 32'(product));
                    n_normal_time = sat_add32(r_normal_time, 32'(rd_cmd.duration));
                    if (r_normal_cnt != 16'hFFFF) begin
                        n_normal_cnt = r_normal_cnt + 16'd1;
                    end
                    if (rd_cmd.speed > r_peak) begin
                        n_peak = rd_cmd.speed;
                    end
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
        // Every result carries the totals after its own step.
        n_out.elapsed_time       = n_time_total;
        n_out.weighted_speed_sum = n_speed_time;
        n_out.run_time_total     = n_normal_time;
        n_out.normal_count       = n_normal_cnt;
        n_out.max_speed          = n_peak;
    end

    // Control and statistics registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_u_head      <= '0;
            r_u_tail      <= '0;
            r_u_fill      <= '0;
            r_n_head      <= '0;
            r_n_tail      <= '0;
            r_n_fill      <= '0;
            r_sel_urgent  <= 1'b0;
            r_time_total  <= '0;
            r_speed_time  <= '0;
            r_normal_time <= '0;
            r_normal_cnt  <= '0;
            r_peak        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_u_head      <= n_u_head;
            r_u_tail      <= n_u_tail;
            r_u_fill      <= n_u_fill;
            r_n_head      <= n_n_head;
            r_n_tail      <= n_n_tail;
            r_n_fill      <= n_n_fill;
            r_sel_urgent  <= n_sel_urgent;
            r_time_total  <= n_time_total;
            r_speed_time  <= n_speed_time;
            r_normal_time <= n_normal_time;
            r_normal_cnt  <= n_normal_cnt;
            r_peak        <= n_peak;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // A queue never holds more than its depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_u_fill <= FILL_W'(QUEUE_DEPTH)) && (r_n_fill <= FILL_W'(QUEUE_DEPTH)))
        else $error("command queue fill exceeds depth");

    // The result register is free whenever a popped command comes back from its store.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> !r_out_valid)
        else $error("result register busy while a command completes");

    // An empty queue has its pointers together.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_u_fill == '0) |-> (r_u_head == r_u_tail))
        else $error("urgent queue pointers disagree with its fill");

    // An execute returns to idle, with its result valid, in the cycle after ST_EXEC.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("execute did not complete");

endmodule

/* test/tb_two_level_priority_command_queue_core.sv */
`timescale 1ns / 1ps

module tb_two_level_priority_command_queue_core;
    import tpcq_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_ITEMS  = 200;

    // Predicts the status report for every command transfer and checks the reports.
    class command_queue_scoreboard;
        t_cmd        urgent_cmds[$];
        t_cmd        normal_cmds[$];
        logic [31:0] time_total      = '0;
        logic [31:0] speed_time_sum  = '0;
        logic [31:0] normal_time_sum = '0;
        logic [15:0] normal_executed = '0;
        logic [7:0]  peak_speed      = '0;
        t_out_item   predicted_reports[$];
        int          mismatches      = 0;

        function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        endfunction

        function string describe(t_out_item r);
            return $sformatf({"valid=%0d mot=%0d spd=%0d dur=%0d urg=%0d full=%0d ",
                              "elapsed=%0d wsum=%0d run=%0d cnt=%0d max=%0d"},
                             r.command_valid, r.out_motion, r.out_speed, r.out_duration,
                             r.was_urgent, r.queue_full, r.elapsed_time,
                             r.weighted_speed_sum, r.run_time_total, r.normal_count,
                             r.max_speed);
        endfunction

        function int pending();
            return predicted_reports.size();
        endfunction

        // Apply one accepted command to the queue model and record the report it causes.
        function void note_command(t_in_item it);
            t_out_item rep;
            t_cmd      cmd;
            rep = '0;
            cmd.motion   = it.motion;
            cmd.speed    = it.speed;
            cmd.duration = it.duration;
            case (t_op'(it.operation))
                OP_ENQ_NORMAL: begin
                    if (normal_cmds.size() < QUEUE_DEPTH) normal_cmds.push_back(cmd);
                    else rep.queue_full = 1'b1;
                end
                OP_ENQ_URGENT: begin
                    if (urgent_cmds.size() < QUEUE_DEPTH) urgent_cmds.push_back(cmd);
                    else rep.queue_full = 1'b1;
                end
                OP_EXECUTE: begin
                    // Urgent commands always go first.
                    if (urgent_cmds.size() > 0) begin
                        cmd = urgent_cmds.pop_front();
                        rep.command_valid = 1'b1;
                        rep.was_urgent    = 1'b1;
                    end else if (normal_cmds.size() > 0) begin
                        cmd = normal_cmds.pop_front();
                        rep.command_valid = 1'b1;
                    end
                    if (rep.command_valid) begin
                        rep.out_motion   = cmd.motion;
                        rep.out_speed    = cmd.speed;
                        rep.out_duration = cmd.duration;
                        time_total = sat_add(time_total, 32'(cmd.duration));
                        if (!rep.was_urgent) begin
                            speed_time_sum  = sat_add(speed_time_sum,
                                                      32'(cmd.speed) * 32'(cmd.duration));
                            normal_time_sum = sat_add(normal_time_sum, 32'(cmd.duration));
                            if (normal_executed != 16'hFFFF) normal_executed++;
                            if (cmd.speed > peak_speed) peak_speed = cmd.speed;
                        end
                    end
                end
                default: begin
                end
            endcase
            // Every report carries the running totals.
            rep.elapsed_time       = time_total;
            rep.weighted_speed_sum = speed_time_sum;
            rep.run_time_total     = normal_time_sum;
            rep.normal_count       = normal_executed;
            rep.max_speed          = peak_speed;
            predicted_reports.push_back(rep);
        endfunction

        // Compare one report against the oldest prediction.
        function void check_report(t_out_item got);
            t_out_item exp;
            if (predicted_reports.size() == 0) begin
                if (mismatches < 10) $display("Unexpected report: %s", describe(got));
                mismatches++;
                return;
            end
            exp = predicted_reports.pop_front();
            if (got.command_valid      !== exp.command_valid      ||
                got.out_motion         !== exp.out_motion         ||
                got.out_speed          !== exp.out_speed          ||
                got.out_duration       !== exp.out_duration       ||
                got.was_urgent         !== exp.was_urgent         ||
                got.queue_full         !== exp.queue_full         ||
                got.elapsed_time       !== exp.elapsed_time       ||
                got.weighted_speed_sum !== exp.weighted_speed_sum ||
                got.run_time_total     !== exp.run_time_total     ||
                got.normal_count       !== exp.normal_count       ||
                got.max_speed          !== exp.max_speed) begin
                if (mismatches < 10) begin
                    $display("Report mismatch at %0t", $realtime);
                    $display("  expected: %s", describe(exp));
                    $display("  actual:   %s", describe(got));
                end
                mismatches++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_result;

    command_queue_scoreboard sb = new();
    bit send_idle_en;
    bit recv_idle_en;
    int cycle_count;

    two_level_priority_command_queue_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Bytes lean toward the extremes so that the totals see large products.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_op rand_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) return OP_ENQ_NORMAL;
        if (pick < 50) return OP_ENQ_URGENT;
        if (pick < 95) return OP_EXECUTE;
        return OP_NONE;
    endfunction

    // Present one command and hold it until its transfer; push stays high afterwards.
    task automatic send_cmd(input t_op op, input logic [2:0] motion,
                            input logic [7:0] speed, input logic [7:0] duration);
        t_in_item it;
        it.operation = op;
        it.motion    = motion;
        it.speed     = speed;
        it.duration  = duration;
        if (send_idle_en && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_command(it);
    endtask

    // Stop sending and wait until every predicted report has come back.
    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Overflow one queue, with random content, so that the last pushes are rejected.
    task automatic fill_queue(input t_op op);
        repeat (QUEUE_DEPTH + 3) send_cmd(op, 3'($urandom_range(0, 7)), rand_byte(),
                                          rand_byte());
    endtask

    // Result side: take reports with random stall bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) sb.check_report(o_result);
            if (stall_left > 0) stall_left--;
            else if (recv_idle_en && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 5);
            pop <= (stall_left == 0);
        end
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_item       <= '0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty execute, no-op, field extremes, priority order.
        send_cmd(OP_EXECUTE,    3'd0, 8'h00, 8'h00);
        send_cmd(OP_NONE,       3'd7, 8'hFF, 8'hFF);
        send_cmd(OP_ENQ_NORMAL, 3'd0, 8'h00, 8'h00);
        send_cmd(OP_ENQ_NORMAL, 3'd7, 8'hFF, 8'hFF);
        send_cmd(OP_ENQ_URGENT, 3'd4, 8'hFF, 8'h01);
        send_cmd(OP_ENQ_URGENT, 3'd5, 8'h00, 8'hFF);
        send_cmd(OP_ENQ_NORMAL, 3'd1, 8'h80, 8'hC8);
        send_cmd(OP_NONE,       3'd0, 8'h00, 8'h00);
        repeat (5) send_cmd(OP_EXECUTE, 3'd7, 8'hFF, 8'hFF);
        send_cmd(OP_EXECUTE,    3'd2, 8'h55, 8'hAA);
        send_cmd(OP_ENQ_NORMAL, 3'd6, 8'h0A, 8'h03);
        send_cmd(OP_ENQ_URGENT, 3'd3, 8'h01, 8'h00);
        send_cmd(OP_EXECUTE,    3'd0, 8'h00, 8'h00);
        send_cmd(OP_EXECUTE,    3'd0, 8'h00, 8'h00);
        send_cmd(OP_EXECUTE,    3'd0, 8'h00, 8'h00);
        wait_drained();

        // Both queues overflow, then drain completely with urgent entries first.
        fill_queue(OP_ENQ_URGENT);
        fill_queue(OP_ENQ_NORMAL);
        repeat (2 * QUEUE_DEPTH + 2) send_cmd(OP_EXECUTE, 3'($urandom_range(0, 7)),
                                              rand_byte(), rand_byte());
        wait_drained();

        // Random mix in blocks, idling switched per block, some blocks drain first.
        for (int blk = 0; blk < (RANDOM_ITEMS - QUIET_ITEMS) / 100; blk++) begin
            send_idle_en = ($urandom_range(0, 3) != 0);
            recv_idle_en = ($urandom_range(0, 3) != 0);
            repeat (100) send_cmd(rand_op(), 3'($urandom_range(0, 7)), rand_byte(),
                                  rand_byte());
            if ($urandom_range(0, 2) == 0) wait_drained();
        end

        // Final stretch at full rate on both sides.
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        repeat (QUIET_ITEMS) send_cmd(rand_op(), 3'($urandom_range(0, 7)), rand_byte(),
                                      rand_byte());
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/tpcq_pkg.sv
hw/rtl/tpcq_ram.sv
hw/rtl/tpcq_front.sv
hw/rtl/tpcq_back.sv
hw/rtl/two_level_priority_command_queue_core.sv
test/tb_two_level_priority_command_queue_core.sv
